/* hw/rtl/bvre_pkg.sv */
// Package for the bit vector range engine: command and status codes,
// field widths and stream bus widths.
// No dependencies.
package bvre_pkg;

  localparam int CMD_W       = 3;
  localparam int BIDX_W      = 9;
  localparam int BYTE_W      = 8;
  localparam int POS_W       = 13;
  localparam int ST_W        = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CMD_W-1:0] CMD_WRITE_BYTE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ_BYTE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_COUNT_RANGE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FILL_RANGE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_APPEND_BIT  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RESIZE      = 3'd5;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_RANGE = 2'd2;

endpackage

/* hw/rtl/bit_vector_range_engine.sv */
// Top level of the bit vector range engine: byte store, length register,
// byte-walking sequencer and output register.
// Depends on bvre_pkg.
//
// The engine holds a bit vector of up to STORE_BYTES*8 bits in a single-port
// byte memory plus a length in bits, and returns exactly one result for each
// command transfer. One shared read-modify-write unit walks the memory one
// byte at a time: a registered read, then a merge and write. A write_byte,
// an append that opens a new byte, a full append, a resize that does not
// grow, an empty range and every rejected command need no walk; a read_byte
// and an append into a started byte walk one byte; count_range, fill_range
// and a growing resize walk each byte the range touches. The input side
// accepts only while the sequencer is idle; a finished result waits in the
// output register, so the next command can run while it is not yet taken.
// The memory is not cleared at reset; a byte must be written before it is read.
module bit_vector_range_engine #(
  parameter int STORE_BYTES = 512
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // byte_index, byte_data, range_start, range_end, bit_value
  input  logic [bvre_pkg::IN_TDATA_W-1:0]  in_tdata,
  // command
  input  logic [bvre_pkg::CMD_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // read_byte_out, ones_count, current_length, status
  output logic [bvre_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bvre_pkg::*;

  localparam int CAP_BITS = STORE_BYTES * 8;
  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int LW = ($clog2(CAP_BITS + 1) > POS_W) ? $clog2(CAP_BITS + 1) : POS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WR   = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  function automatic logic [3:0] popcnt8(input logic [7:0] v);
    logic [3:0] s;
    s = 4'd0;
    for (int i = 0; i < 8; i++) begin
      s = s + {3'd0, v[i]};
    end
    return s;
  endfunction

  logic [7:0]        store_r [STORE_BYTES];
  logic [7:0]        mem_q_r;

  logic [1:0]        state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [AW-1:0]     first_r, first_nxt;
  logic [AW-1:0]     last_r, last_nxt;
  logic [2:0]        lo_r, lo_nxt;
  logic [2:0]        hi_r, hi_nxt;
  logic              bv_r, bv_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [LW-1:0]     cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] rd_r, rd_nxt;
  logic [ST_W-1:0]   st_r, st_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_rd_r, out_rd_nxt;
  logic [POS_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [POS_W-1:0]  out_len_r, out_len_nxt;
  logic [ST_W-1:0]   out_st_r, out_st_nxt;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr;
  logic [7:0]        mem_wdata;

  logic [BIDX_W-1:0] f_bidx;
  logic [BYTE_W-1:0] f_bdata;
  logic [POS_W-1:0]  f_rs, f_re, f_re_m1;
  logic              f_bv;
  logic              accept;
  logic              bidx_bad;
  logic [2:0]        lo_sel, hi_sel;
  logic [7:0]        mask;

  assign f_bidx  = in_tdata[8:0];
  assign f_bdata = in_tdata[16:9];
  assign f_rs    = in_tdata[29:17];
  assign f_re    = in_tdata[42:30];
  assign f_bv    = in_tdata[43];
  assign f_re_m1 = f_re - 13'd1;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign bidx_bad  = (32'(f_bidx) >= 32'(STORE_BYTES));

  assign lo_sel = (addr_r == first_r) ? lo_r : 3'd0;
  assign hi_sel = (addr_r == last_r) ? hi_r : 3'd7;
  assign mask   = (8'hFF << lo_sel) & (8'hFF >> (3'd7 - hi_sel));

  assign mem_re = (state_r == S_RD);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    bv_nxt        = bv_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    rd_nxt        = rd_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    out_rd_nxt    = out_rd_r;
    out_cnt_nxt   = out_cnt_r;
    out_len_nxt   = out_len_r;
    out_st_nxt    = out_st_r;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = (mem_q_r & ~mask) | (bv_r ? mask : 8'h00);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_tuser;
          cnt_nxt   = '0;
          rd_nxt    = '0;
          st_nxt    = ST_OK;
          bv_nxt    = f_bv;
          state_nxt = S_DONE;
          unique case (in_tuser)
            CMD_WRITE_BYTE: begin
              if (bidx_bad) begin
                st_nxt = ST_BAD_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(f_bidx);
                mem_wdata = f_bdata;
              end
            end
            CMD_READ_BYTE: begin
              if (bidx_bad) begin
                st_nxt = ST_BAD_RANGE;
              end else begin
                addr_nxt  = AW'(f_bidx);
                first_nxt = AW'(f_bidx);
                last_nxt  = AW'(f_bidx);
                state_nxt = S_RD;
              end
            end
            CMD_COUNT_RANGE, CMD_FILL_RANGE: begin
              if (LW'(f_rs) > len_r || LW'(f_re) > len_r) begin
                st_nxt = ST_BAD_RANGE;
              end else if (f_rs < f_re) begin
                addr_nxt  = AW'(f_rs >> 3);
                first_nxt = AW'(f_rs >> 3);
                last_nxt  = AW'(f_re_m1 >> 3);
                lo_nxt    = f_rs[2:0];
                hi_nxt    = f_re_m1[2:0];
                state_nxt = S_RD;
              end
            end
            CMD_APPEND_BIT: begin
              if (len_r >= LW'(CAP_BITS)) begin
                st_nxt = ST_FULL;
              end else begin
                len_nxt = len_r + LW'(1);
                if (len_r[2:0] == 3'd0) begin
                  mem_we    = 1'b1;
                  mem_waddr = AW'(len_r >> 3);
                  mem_wdata = {7'd0, f_bv};
                end else begin
                  addr_nxt  = AW'(len_r >> 3);
                  first_nxt = AW'(len_r >> 3);
                  last_nxt  = AW'(len_r >> 3);
                  lo_nxt    = len_r[2:0];
                  hi_nxt    = len_r[2:0];
                  state_nxt = S_RD;
                end
              end
            end
            CMD_RESIZE: begin
              if (32'(f_re) > 32'(CAP_BITS)) begin
                st_nxt = ST_BAD_RANGE;
              end else begin
                len_nxt = LW'(f_re);
                if (LW'(f_re) > len_r) begin
                  bv_nxt    = 1'b0;
                  addr_nxt  = AW'(len_r >> 3);
                  first_nxt = AW'(len_r >> 3);
                  last_nxt  = AW'(f_re_m1 >> 3);
                  lo_nxt    = len_r[2:0];
                  hi_nxt    = 3'd7;
                  state_nxt = S_RD;
                end
              end
            end
            default: begin
              st_nxt = ST_BAD_RANGE;
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        priority if (cmd_r == CMD_READ_BYTE) begin
          rd_nxt = mem_q_r;
        end else if (cmd_r == CMD_COUNT_RANGE) begin
          cnt_nxt = cnt_r + LW'(popcnt8(mem_q_r & mask));
        end else begin
          mem_we = 1'b1;
        end
        if (addr_r == last_r) begin
          state_nxt = S_DONE;
        end else begin
          addr_nxt  = addr_r + AW'(1);
          state_nxt = S_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = rd_r;
          out_cnt_nxt   = POS_W'(cnt_r);
          out_len_nxt   = POS_W'(len_r);
          out_st_nxt    = st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= store_r[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    addr_r    <= addr_nxt;
    first_r   <= first_nxt;
    last_r    <= last_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    bv_r      <= bv_nxt;
    cnt_r     <= cnt_nxt;
    rd_r      <= rd_nxt;
    st_r      <= st_nxt;
    out_rd_r  <= out_rd_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_len_r <= out_len_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_st_r, out_len_r, out_cnt_r, out_rd_r};

endmodule

/* hw/rtl/bvre_checker.sv */
// Port-level checker for the bit vector range engine, bound to the top level.
// Depends on bvre_pkg and bit_vector_range_engine.
module bvre_checker #(
  parameter int STORE_BYTES = 512
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [bvre_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bvre_pkg::*;

  logic [BYTE_W-1:0] o_rd;
  logic [POS_W-1:0]  o_cnt, o_len;
  logic [ST_W-1:0]   o_st;

  assign o_rd  = out_tdata[7:0];
  assign o_cnt = out_tdata[20:8];
  assign o_len = out_tdata[33:21];
  assign o_st  = out_tdata[35:34];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result presented right after reset");

  a_error_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_st != ST_OK |-> o_rd == 8'd0 && o_cnt == 13'd0)
    else $error("failed command returned data");

  a_full_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_st == ST_FULL |-> o_len == POS_W'(STORE_BYTES * 8))
    else $error("full status below capacity");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> o_st == ST_OK || o_st == ST_FULL || o_st == ST_BAD_RANGE)
    else $error("undefined status code");

endmodule

bind bit_vector_range_engine bvre_checker #(.STORE_BYTES(STORE_BYTES)) u_bvre_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
